[rtl/sfcd_pkg.sv]
package sfcd_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W           = 7;
    localparam int MAX_LEN_INT     = (MAX_FRAME_BYTES < 64) ? MAX_FRAME_BYTES : 64;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(8);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEN_INT);

    localparam logic [7:0]  POLY8_07       = 8'h07;
    localparam logic [7:0]  POLY8_31       = 8'h31;
    localparam logic [15:0] POLY16_1021    = 16'h1021;
    localparam logic [15:0] POLY16_A001    = 16'hA001;
    localparam logic [15:0] CRC16_LSB_INIT = 16'hFFFF;

    // checksum selection codes, 9..15 behave as none
    typedef enum logic [3:0] {
        CK_NONE        = 4'd0,
        CK_SUM8        = 4'd1,
        CK_XOR8        = 4'd2,
        CK_CRC8_07     = 4'd3,
        CK_CRC8_31     = 4'd4,
        CK_SUM16       = 4'd5,
        CK_XOR16       = 4'd6,
        CK_CRC16_1021  = 4'd7,
        CK_CRC16_A001  = 4'd8
    } ck_kind_t;

    typedef enum logic [2:0] {
        REG_ENABLE        = 3'd0,
        REG_SYNC_FIRST    = 3'd1,
        REG_SYNC_SECOND   = 3'd2,
        REG_TWO_BYTE_SYNC = 3'd3,
        REG_FRAME_LENGTH  = 3'd4,
        REG_CHECKSUM_KIND = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_ACC,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WT,
        ST_BAD_WT
    } state_t;

    typedef struct packed {
        logic take;
        logic idx_clr;
        logic idx_inc;
        logic acc_init;
        logic acc_step;
        logic count_good;
        logic count_bad;
        logic resync;
        logic load_good;
        logic load_bad;
        logic out_done;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic direct;
        logic idx_last;
        logic good;
    } status_t;

    function automatic logic [15:0] check_init(logic [3:0] k);
        return (k == CK_CRC16_A001) ? CRC16_LSB_INIT : 16'h0000;
    endfunction

    // one byte folded into the running checksum
    function automatic logic [15:0] check_fold(logic [3:0] k, logic [15:0] acc,
                                               logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  c8;
        logic [7:0]  poly8;
        c     = acc;
        c8    = acc[7:0] ^ b;
        poly8 = (k == CK_CRC8_07) ? POLY8_07 : POLY8_31;
        case (k) inside
            CK_SUM8: c = {8'h00, 8'(acc[7:0] + b)};
            CK_XOR8, CK_XOR16: c = acc ^ {8'h00, b};
            CK_CRC8_07, CK_CRC8_31:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    c8 = c8[7] ? ({c8[6:0], 1'b0} ^ poly8) : {c8[6:0], 1'b0};
                end
                c = {8'h00, c8};
            end
            CK_SUM16: c = 16'(acc + {8'h00, b});
            CK_CRC16_1021:
            begin
                c = acc ^ {b, 8'h00};
                for (int i = 0; i < 8; i++)
                begin
                    c = c[15] ? ({c[14:0], 1'b0} ^ POLY16_1021) : {c[14:0], 1'b0};
                end
            end
            CK_CRC16_A001:
            begin
                c = acc ^ {8'h00, b};
                for (int i = 0; i < 8; i++)
                begin
                    c = c[0] ? ({1'b0, c[15:1]} ^ POLY16_A001) : {1'b0, c[15:1]};
                end
            end
            default: c = acc;
        endcase
        return c;
    endfunction

endpackage

[rtl/sfcd_ctrl.sv]
module sfcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  sfcd_pkg::status_t st,
    output logic              in_ready,
    output sfcd_pkg::cmd_t    cmd
);

    sfcd_pkg::state_t state_reg;
    sfcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfcd_pkg::ST_IDLE:
            begin
                if (in_valid && st.done)
                begin
                    state_next = st.direct ? sfcd_pkg::ST_EMIT_RD : sfcd_pkg::ST_CHK_RD;
                end
            end
            sfcd_pkg::ST_CHK_RD:  state_next = sfcd_pkg::ST_CHK_ACC;
            sfcd_pkg::ST_CHK_ACC:
            begin
                state_next = st.idx_last ? sfcd_pkg::ST_DECIDE : sfcd_pkg::ST_CHK_RD;
            end
            sfcd_pkg::ST_DECIDE:
            begin
                state_next = st.good ? sfcd_pkg::ST_EMIT_RD : sfcd_pkg::ST_BAD_WT;
            end
            sfcd_pkg::ST_EMIT_RD: state_next = sfcd_pkg::ST_EMIT_LD;
            sfcd_pkg::ST_EMIT_LD: state_next = sfcd_pkg::ST_EMIT_WT;
            sfcd_pkg::ST_EMIT_WT:
            begin
                if (out_ready)
                begin
                    state_next = st.idx_last ? sfcd_pkg::ST_IDLE : sfcd_pkg::ST_EMIT_RD;
                end
            end
            sfcd_pkg::ST_BAD_WT:
            begin
                if (out_ready)
                begin
                    state_next = sfcd_pkg::ST_IDLE;
                end
            end
            default: state_next = sfcd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            sfcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
                if (in_valid && st.done)
                begin
                    cmd.idx_clr    = 1'b1;
                    cmd.acc_init   = !st.direct;
                    cmd.count_good = st.direct;
                end
            end
            sfcd_pkg::ST_CHK_RD: ;
            sfcd_pkg::ST_CHK_ACC:
            begin
                cmd.acc_step = 1'b1;
                cmd.idx_inc  = !st.idx_last;
            end
            sfcd_pkg::ST_DECIDE:
            begin
                cmd.idx_clr    = 1'b1;
                cmd.count_good = st.good;
                cmd.count_bad  = !st.good;
                cmd.resync     = !st.good;
                cmd.load_bad   = !st.good;
            end
            sfcd_pkg::ST_EMIT_RD: ;
            sfcd_pkg::ST_EMIT_LD: cmd.load_good = 1'b1;
            sfcd_pkg::ST_EMIT_WT:
            begin
                cmd.out_done = out_ready;
                cmd.idx_inc  = out_ready && !st.idx_last;
            end
            sfcd_pkg::ST_BAD_WT:  cmd.out_done = out_ready;
            default: ;
        endcase
    end

endmodule

[rtl/sfcd_datapath.sv]
module sfcd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [7:0]        cfg_wdata,
    input  logic [7:0]        rx_byte,
    input  sfcd_pkg::cmd_t    cmd,
    output sfcd_pkg::status_t st,
    output logic              out_valid,
    output logic              kind,
    output logic [7:0]        data,
    output logic              last,
    output logic [31:0]       good_frames,
    output logic [31:0]       bad_frames
);

    localparam int LW = sfcd_pkg::LEN_W;
    localparam int AW = sfcd_pkg::ADDR_W;

    // configuration
    logic          enable_reg;
    logic [7:0]    sync_first_reg;
    logic [7:0]    sync_second_reg;
    logic          two_byte_reg;
    logic [LW-1:0] frame_length_reg;
    logic [3:0]    ck_kind_reg;

    // frame tracking and check
    logic [LW-1:0] fill_reg, fill_next;
    logic          in_frame_reg, in_frame_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [15:0]   acc_reg, acc_next;
    logic [7:0]    tail_hi_reg, tail_hi_next;
    logic [7:0]    tail_lo_reg, tail_lo_next;
    logic [7:0]    last_byte_reg, last_byte_next;
    logic [31:0]   good_cnt_reg, good_cnt_next;
    logic [31:0]   bad_cnt_reg, bad_cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    logic [7:0]    store_mem [sfcd_pkg::MAX_FRAME_BYTES];
    logic [7:0]    rdata_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [LW-1:0] len;
    logic [LW-1:0] fill_inc;
    logic [LW-1:0] chk_n;
    logic          short_chk;
    logic          checked;
    logic          done;

    always_comb
    begin
        if (frame_length_reg < sfcd_pkg::MIN_LEN)
        begin
            len = sfcd_pkg::MIN_LEN;
        end
        else if (frame_length_reg > sfcd_pkg::MAX_LEN)
        begin
            len = sfcd_pkg::MAX_LEN;
        end
        else
        begin
            len = frame_length_reg;
        end
    end

    assign fill_inc  = fill_reg + LW'(1);
    assign short_chk = (ck_kind_reg <= sfcd_pkg::CK_CRC8_31);
    assign chk_n     = short_chk ? (len - LW'(1)) : (len - LW'(2));
    assign checked   = (ck_kind_reg != sfcd_pkg::CK_NONE)
                       && (ck_kind_reg <= sfcd_pkg::CK_CRC16_A001);

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            sync_first_reg   <= 8'h00;
            sync_second_reg  <= 8'h00;
            two_byte_reg     <= 1'b0;
            frame_length_reg <= LW'(8);
            ck_kind_reg      <= sfcd_pkg::CK_SUM8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                sfcd_pkg::REG_ENABLE:        enable_reg       <= cfg_wdata[0];
                sfcd_pkg::REG_SYNC_FIRST:    sync_first_reg   <= cfg_wdata;
                sfcd_pkg::REG_SYNC_SECOND:   sync_second_reg  <= cfg_wdata;
                sfcd_pkg::REG_TWO_BYTE_SYNC: two_byte_reg     <= cfg_wdata[0];
                sfcd_pkg::REG_FRAME_LENGTH:  frame_length_reg <= cfg_wdata[LW-1:0];
                sfcd_pkg::REG_CHECKSUM_KIND: ck_kind_reg      <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // byte intake: sync search and store fill
    always_comb
    begin
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        wr_en         = 1'b0;
        wr_addr       = fill_reg[AW-1:0];
        wr_data       = rx_byte;
        done          = 1'b0;
        if (enable_reg)
        begin
            if (two_byte_reg && !in_frame_reg && (fill_reg == '0))
            begin
                if (rx_byte == sync_first_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    fill_next = LW'(1);
                end
            end
            else if (two_byte_reg && !in_frame_reg && (fill_reg == LW'(1)))
            begin
                if (rx_byte == sync_second_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = AW'(1);
                    fill_next     = LW'(2);
                    in_frame_next = 1'b1;
                end
                else if (rx_byte == sync_first_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    fill_next = LW'(1);
                end
                else
                begin
                    fill_next = '0;
                end
            end
            else if (!two_byte_reg && !in_frame_reg)
            begin
                if (rx_byte == sync_first_reg)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = '0;
                    fill_next     = LW'(1);
                    in_frame_next = 1'b1;
                end
            end
            else
            begin
                wr_en = (fill_reg < LW'(sfcd_pkg::MAX_FRAME_BYTES));
                if (fill_inc < len)
                begin
                    fill_next = fill_inc;
                end
                else
                begin
                    fill_next     = '0;
                    in_frame_next = 1'b0;
                    done          = 1'b1;
                end
            end
        end
        if (!cmd.take)
        begin
            fill_next     = fill_reg;
            in_frame_next = in_frame_reg;
            wr_en         = 1'b0;
            done          = 1'b0;
        end
        // resync on the final byte of a bad frame
        if (cmd.resync && (last_byte_reg == sync_first_reg))
        begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = last_byte_reg;
            fill_next     = LW'(1);
            in_frame_next = 1'b1;
        end
    end

    always_comb
    begin
        st.done     = done;
        st.direct   = two_byte_reg || !checked;
        st.idx_last = (idx_reg == (len - LW'(1)));
        if (short_chk)
        begin
            st.good = (acc_reg[7:0] == tail_hi_reg);
        end
        else
        begin
            st.good = (acc_reg == {tail_hi_reg, tail_lo_reg})
                      || (acc_reg == {tail_lo_reg, tail_hi_reg});
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        tail_hi_next   = tail_hi_reg;
        tail_lo_next   = tail_lo_reg;
        last_byte_next = cmd.take ? rx_byte : last_byte_reg;
        good_cnt_next  = cmd.count_good ? (good_cnt_reg + 32'd1) : good_cnt_reg;
        bad_cnt_next   = cmd.count_bad ? (bad_cnt_reg + 32'd1) : bad_cnt_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + LW'(1);
        end

        if (cmd.acc_init)
        begin
            acc_next = sfcd_pkg::check_init(ck_kind_reg);
        end
        else if (cmd.acc_step)
        begin
            if (idx_reg < chk_n)
            begin
                acc_next = sfcd_pkg::check_fold(ck_kind_reg, acc_reg, rdata_reg);
            end
            tail_hi_next = rdata_reg;
            tail_lo_next = tail_hi_reg;
        end

        if (cmd.load_good)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b0;
            out_data_next  = rdata_reg;
            out_last_next  = st.idx_last;
        end
        else if (cmd.load_bad)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = 1'b1;
            out_data_next  = 8'h00;
            out_last_next  = 1'b1;
        end
        else if (cmd.out_done)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            in_frame_reg  <= 1'b0;
            idx_reg       <= '0;
            good_cnt_reg  <= '0;
            bad_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            in_frame_reg  <= in_frame_next;
            idx_reg       <= idx_next;
            good_cnt_reg  <= good_cnt_next;
            bad_cnt_reg   <= bad_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        tail_hi_reg   <= tail_hi_next;
        tail_lo_reg   <= tail_lo_next;
        last_byte_reg <= last_byte_next;
        out_kind_reg  <= out_kind_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= store_mem[idx_reg[AW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign data        = out_data_reg;
    assign last        = out_last_reg;
    assign good_frames = good_cnt_reg;
    assign bad_frames  = bad_cnt_reg;

endmodule

[rtl/sync_frame_checksum_deframer_unit.sv]
// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_addr[2:0], cfg_wdata[7:0]
// rx        in         in_valid / in_ready   rx_byte[7:0]
// result    out        out_valid / out_ready kind, data[7:0], last, good_frames, bad_frames
//
// bytes inside a frame are taken one per cycle; the frame store has one write port
// at frame end, with one-byte sync and a checksum selected, the checksum unit walks
// the store, each byte a registered read then a fold, with in_ready low meanwhile
// a good frame drains byte by byte through the output register (read, load, wait),
// a bad frame gives one transaction; out_ready low just holds the output register
// reset clears control state, counters and config; the store keeps no reset
module sync_frame_checksum_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  data,
    output logic        last,
    output logic [31:0] good_frames,
    output logic [31:0] bad_frames
);

    // command and status between sequencer and datapath
    sfcd_pkg::cmd_t    cmd;
    sfcd_pkg::status_t st;

    // sequencer: sync intake, checksum walk, verdict, drain
    sfcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .st        (st),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // datapath: config registers, frame store, checksum, counters, output register
    sfcd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .st          (st),
        .out_valid   (out_valid),
        .kind        (kind),
        .data        (data),
        .last        (last),
        .good_frames (good_frames),
        .bad_frames  (bad_frames)
    );

endmodule

[rtl/sfcd_checker.sv]
module sfcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        kind,
    input logic [7:0]  data,
    input logic        last,
    input logic [31:0] good_frames,
    input logic [31:0] bad_frames
);

    // intake is closed while a result is pending
    a_no_intake_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // a bad event is a single last transaction with no data
    a_bad_event_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> last && (data == 8'h00))
        else $error("malformed bad frame event");

    // the good frame counter steps by at most one per cycle
    a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ((good_frames == $past(good_frames))
             || (good_frames == $past(good_frames) + 32'd1)))
        else $error("good frame count jumped");

    // counters hold while results drain
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(out_valid) |-> $stable(good_frames) && $stable(bad_frames))
        else $error("frame count changed during drain");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data)
                                    && $stable(last))
        else $error("stalled result changed");

endmodule

bind sync_frame_checksum_deframer_unit sfcd_checker u_sfcd_checker (.*);
